// ----- sv/sipf_pkg.sv -----
`timescale 1ns / 1ps

package sipf_pkg;

   localparam logic [7:0] HDR_BYTE  = 8'hFF;
   localparam logic [7:0] MAX_COUNT = 8'd253;
   localparam logic [7:0] LEN_EXTRA = 8'd2;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_PARAM = 1'b1
   } kind_type;

   // Byte position inside a packet; parameter frames start at SLOT_MID
   typedef enum logic [2:0] {
      SLOT_HDR0 = 3'd0,
      SLOT_HDR1 = 3'd1,
      SLOT_ID   = 3'd2,
      SLOT_LEN  = 3'd3,
      SLOT_MID  = 3'd4,
      SLOT_CHK  = 3'd5
   } slot_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] servo_id;
      logic [7:0] instruction;
      logic [7:0] param_count;
      logic [7:0] data_byte;
   } req_item_type;

   // Bytes one input item puts on the wire, replayed by the serializer
   typedef struct packed {
      slot_type   first;
      logic [7:0] servo_id;
      logic [7:0] len;
      logic [7:0] mid;
      logic [7:0] chk;
      logic       has_chk;
   } frame_type;

endpackage

// ----- sv/sipf_channels.sv -----
`timescale 1ns / 1ps

interface sipf_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] servo_id;
   logic [7:0] instruction;
   logic [7:0] param_count;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output servo_id, output instruction,
                   output param_count, output data_byte, input ready);
   modport sink   (input valid, input kind, input servo_id, input instruction,
                   input param_count, input data_byte, output ready);
endinterface

interface sipf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       packet_end;

   modport source (output valid, output tx_byte, output packet_end, input ready);
   modport sink   (input valid, input tx_byte, input packet_end, output ready);
endinterface

// ----- sv/servo_instruction_packet_framer_core.sv -----
`timescale 1ns / 1ps

// Servo bus instruction packet framer. A start item (kind 0) emits 0xFF 0xFF,
// id, length (count+2, count capped at 253) and instruction, plus the checksum
// when the count is zero; each parameter item (kind 1) emits its byte and,
// after the last one, the inverted low-byte checksum with packet_end set.
// Parameter items outside a packet are dropped; a start abandons an open
// packet. Output runs at one byte per cycle while rsp_if.ready stays high,
// so a start item fills 5 or 6 result bytes and a parameter item 1 or 2.
// Packet state updates when an item is accepted; the frame then goes to the
// byte serializer's active register, or waits in a one-entry buffer ahead of
// it while a frame is being sent. req_if.ready drops only while that buffer
// is full, so a new item can be taken before the last frame is fully sent.
module servo_instruction_packet_framer_core (
   input logic       clock,
   input logic       reset,
   sipf_req_if.sink  req_if,
   sipf_rsp_if.source rsp_if
);
   import sipf_pkg::*;

   req_item_type item;
   frame_type    frame;
   logic         emit;
   logic         room;
   logic         accept;

   assign item.kind        = req_if.kind;
   assign item.servo_id    = req_if.servo_id;
   assign item.instruction = req_if.instruction;
   assign item.param_count = req_if.param_count;
   assign item.data_byte   = req_if.data_byte;

   assign req_if.ready = room;
   assign accept       = req_if.valid && room;

   sipf_builder u_builder (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .emit   (emit),
      .frame  (frame)
   );

   sipf_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .emit   (emit),
      .frame  (frame),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule

// ----- sv/sipf_builder.sv -----
`timescale 1ns / 1ps

module sipf_builder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  sipf_pkg::req_item_type item,
   output logic                  emit,
   output sipf_pkg::frame_type   frame
);
   import sipf_pkg::*;

   logic [7:0] sum_acc_ff, sum_acc_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       in_packet_ff, in_packet_in;

   logic [7:0] count;
   logic [7:0] len;
   logic [7:0] start_sum;
   logic [7:0] param_sum;
   logic [7:0] left_dec;

   always_comb begin
      count     = (item.param_count > MAX_COUNT) ? MAX_COUNT : item.param_count;
      len       = count + LEN_EXTRA;
      start_sum = item.servo_id + len + item.instruction;
      param_sum = sum_acc_ff + item.data_byte;
      left_dec  = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : 8'd0;

      sum_acc_in    = sum_acc_ff;
      bytes_left_in = bytes_left_ff;
      in_packet_in  = in_packet_ff;
      emit          = 1'b0;
      frame.first    = SLOT_HDR0;
      frame.servo_id = item.servo_id;
      frame.len      = len;
      frame.mid      = item.instruction;
      frame.chk      = ~start_sum;
      frame.has_chk  = (count == 8'd0);

      if (accept) begin
         if (item.kind == KIND_START) begin
            // a start abandons any open packet
            emit          = 1'b1;
            sum_acc_in    = start_sum;
            bytes_left_in = count;
            in_packet_in  = (count != 8'd0);
         end else if (in_packet_ff) begin
            emit          = 1'b1;
            frame.first   = SLOT_MID;
            frame.mid     = item.data_byte;
            frame.chk     = ~param_sum;
            frame.has_chk = (left_dec == 8'd0);
            sum_acc_in    = param_sum;
            bytes_left_in = left_dec;
            in_packet_in  = (left_dec != 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_acc_ff    <= 8'd0;
         bytes_left_ff <= 8'd0;
         in_packet_ff  <= 1'b0;
      end else begin
         sum_acc_ff    <= sum_acc_in;
         bytes_left_ff <= bytes_left_in;
         in_packet_ff  <= in_packet_in;
      end
   end

endmodule

// ----- sv/sipf_serializer.sv -----
`timescale 1ns / 1ps

module sipf_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                emit,
   input  sipf_pkg::frame_type frame,
   output logic                room,
   sipf_rsp_if.source          rsp_if
);
   import sipf_pkg::*;

   frame_type act_ff, act_in;
   slot_type  slot_ff, slot_in;
   logic      act_valid_ff, act_valid_in;
   frame_type pend_ff, pend_in;
   logic      pend_valid_ff, pend_valid_in;

   logic last;
   logic take;
   logic act_free;

   assign room = !pend_valid_ff;

   always_comb begin
      case (slot_ff)
         SLOT_HDR0: rsp_if.tx_byte = HDR_BYTE;
         SLOT_HDR1: rsp_if.tx_byte = HDR_BYTE;
         SLOT_ID:   rsp_if.tx_byte = act_ff.servo_id;
         SLOT_LEN:  rsp_if.tx_byte = act_ff.len;
         SLOT_MID:  rsp_if.tx_byte = act_ff.mid;
         SLOT_CHK:  rsp_if.tx_byte = act_ff.chk;
         default:   rsp_if.tx_byte = act_ff.chk;
      endcase
   end

   assign rsp_if.valid      = act_valid_ff;
   assign rsp_if.packet_end = (slot_ff == SLOT_CHK);

   always_comb begin
      last     = (slot_ff == SLOT_CHK) || (slot_ff == SLOT_MID && !act_ff.has_chk);
      take     = rsp_if.valid && rsp_if.ready;
      act_free = !act_valid_ff || (take && last);

      act_in        = act_ff;
      slot_in       = slot_ff;
      act_valid_in  = act_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;

      if (take && !last) begin
         slot_in = slot_type'(slot_ff + 3'd1);
      end

      if (act_free) begin
         // the pending frame goes first; otherwise a new one skips the buffer
         if (pend_valid_ff) begin
            act_in       = pend_ff;
            slot_in      = pend_ff.first;
            act_valid_in = 1'b1;
         end else begin
            act_in       = frame;
            slot_in      = frame.first;
            act_valid_in = emit;
         end
         pend_valid_in = 1'b0;
      end else if (emit) begin
         pend_in       = frame;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      pend_ff <= pend_in;
      if (reset) begin
         slot_ff       <= SLOT_HDR0;
         act_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         slot_ff       <= slot_in;
         act_valid_ff  <= act_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

// ----- sv/sipf_checker.sv -----
`timescale 1ns / 1ps

module sipf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_packet_end
);

   // stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte)
                                  && $stable(rsp_packet_end))
      else $error("rsp item changed while stalled");

   // back-pressure on req only while a frame is being sent
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no output pending");

   // the framer comes out of reset empty and ready
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // an accepted item with idle output yields a byte next cycle or is dropped;
   // either way the input side stays open
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> req_ready)
      else $error("req stalled after item into idle framer");

endmodule

bind servo_instruction_packet_framer_core sipf_checker u_sipf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_tx_byte    (rsp_if.tx_byte),
   .rsp_packet_end (rsp_if.packet_end)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import sipf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 80;
   localparam int BURST_COUNT  = 12;
   localparam int TAIL_CYCLES  = 16;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       packet_end;
   } wire_byte_type;

   // Tracks packet framing state and the bytes owed on the wire
   class packet_byte_tracker;
      logic [7:0]    checksum_acc;
      logic [7:0]    params_left;
      bit            packet_open;
      wire_byte_type wire_bytes_due[$];
      int            errors;

      function new();
         checksum_acc = '0;
         params_left  = '0;
         packet_open  = 1'b0;
         errors       = 0;
      endfunction

      function void owe_byte(logic [7:0] value, logic last);
         wire_byte_type wb;
         wb.tx_byte    = value;
         wb.packet_end = last;
         wire_bytes_due.push_back(wb);
      endfunction

      function void frame_item(req_item_type it);
         logic [7:0] count;
         logic [7:0] len;
         if (it.kind == KIND_START) begin
            count = (it.param_count > MAX_COUNT) ? MAX_COUNT : it.param_count;
            len   = count + LEN_EXTRA;
            owe_byte(HDR_BYTE, 1'b0);
            owe_byte(HDR_BYTE, 1'b0);
            owe_byte(it.servo_id, 1'b0);
            owe_byte(len, 1'b0);
            owe_byte(it.instruction, 1'b0);
            checksum_acc = it.servo_id + len + it.instruction;
            params_left  = count;
            if (count == 8'd0) begin
               owe_byte(~checksum_acc, 1'b1);
               packet_open = 1'b0;
            end else begin
               packet_open = 1'b1;
            end
         end else if (packet_open) begin
            owe_byte(it.data_byte, 1'b0);
            checksum_acc = checksum_acc + it.data_byte;
            if (params_left != 8'd0) params_left = params_left - 8'd1;
            if (params_left == 8'd0) begin
               owe_byte(~checksum_acc, 1'b1);
               packet_open = 1'b0;
            end
         end
      endfunction

      function void match_wire_byte(logic [7:0] tx, logic last);
         wire_byte_type wb;
         if (wire_bytes_due.size() == 0) begin
            $display("%0t: unexpected byte: expected none, got tx_byte %h packet_end %b",
                     $time, tx, last);
            errors++;
            return;
         end
         wb = wire_bytes_due.pop_front();
         if (tx !== wb.tx_byte || last !== wb.packet_end) begin
            $display("%0t: byte mismatch: expected tx_byte %h packet_end %b, got %h %b",
                     $time, wb.tx_byte, wb.packet_end, tx, last);
            errors++;
         end
      endfunction

      function int bytes_owed();
         return wire_bytes_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   send_gap_max;
   int   take_stall_max;

   packet_byte_tracker tracker;

   sipf_req_if req_ch ();
   sipf_rsp_if rsp_ch ();

   servo_instruction_packet_framer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Handshake monitor; all drivers use nonblocking updates, so these are pre-edge values
   always @(posedge clock) begin
      req_item_type it;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it.kind        = req_ch.kind;
            it.servo_id    = req_ch.servo_id;
            it.instruction = req_ch.instruction;
            it.param_count = req_ch.param_count;
            it.data_byte   = req_ch.data_byte;
            tracker.frame_item(it);
         end
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.match_wire_byte(rsp_ch.tx_byte, rsp_ch.packet_end);
      end
   end

   // Result side: random stall before each byte
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = $urandom_range(0, take_stall_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_item(req_item_type it);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= it.kind;
      req_ch.servo_id    <= it.servo_id;
      req_ch.instruction <= it.instruction;
      req_ch.param_count <= it.param_count;
      req_ch.data_byte   <= it.data_byte;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Unused fields get random values to show they are ignored
   task automatic send_start(logic [7:0] id, logic [7:0] instr, logic [7:0] count);
      req_item_type it;
      it.kind        = KIND_START;
      it.servo_id    = id;
      it.instruction = instr;
      it.param_count = count;
      it.data_byte   = 8'($urandom);
      send_item(it);
   endtask

   task automatic send_param(logic [7:0] data);
      req_item_type it;
      it.kind        = KIND_PARAM;
      it.servo_id    = 8'($urandom);
      it.instruction = 8'($urandom);
      it.param_count = 8'($urandom);
      it.data_byte   = data;
      send_item(it);
   endtask

   // Sender goes idle and waits until every owed byte has come out
   task automatic drain_packets();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.bytes_owed() != 0);
   endtask

   function automatic int pick_idle_max();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         default: return 10;
      endcase
   endfunction

   initial begin
      int sent;
      int count;
      int taken;
      int open_left;
      int roll;
      bit drained;

      tracker            = new();
      send_gap_max       = 10;
      take_stall_max     = 10;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_START;
      req_ch.servo_id    = '0;
      req_ch.instruction = '0;
      req_ch.param_count = '0;
      req_ch.data_byte   = '0;

      wait (!reset);
      @(posedge clock);

      // directed: stray params, empty packets, extremes, abandon, count saturation
      send_param(8'hFF);
      send_start(8'h00, 8'h00, 8'd0);
      send_start(8'hFF, 8'hFF, 8'd0);
      send_start(8'hFE, 8'h01, 8'd0);
      send_start(8'h01, 8'h02, 8'd2);
      send_param(8'h00);
      send_param(8'hFF);
      send_param(8'h00);
      send_start(8'h03, 8'h03, 8'd3);
      send_param(8'hAA);
      send_start(8'h55, 8'h04, 8'd1);
      send_param(8'h5A);
      send_start(8'h7F, 8'h80, 8'd255);
      send_param(8'h01);
      send_start(8'h80, 8'h7F, 8'd254);
      send_start(8'hFE, 8'h83, 8'd253);
      send_start(8'h10, 8'h03, 8'd1);
      send_param(8'h80);

      drain_packets();

      // burst with no idling on either side, then a stray param after the checksum
      send_gap_max   = 0;
      take_stall_max = 0;
      send_start(8'($urandom), 8'($urandom), 8'(BURST_COUNT));
      for (int i = 0; i < BURST_COUNT; i++) send_param(8'($urandom));
      send_param(8'($urandom));

      sent      = 0;
      open_left = 0;
      drained   = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         send_gap_max   = pick_idle_max();
         take_stall_max = pick_idle_max();
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
            send_start(8'($urandom), 8'($urandom), 8'(count));
            sent++;
            for (int i = 0; i < count; i++) begin
               send_param(8'($urandom));
               sent++;
            end
            open_left = 0;
         end else if (roll < 90) begin
            // packet cut short; the next start abandons it
            count = $urandom_range(2, 8);
            taken = $urandom_range(1, count - 1);
            send_start(8'($urandom), 8'($urandom), 8'(count));
            sent++;
            for (int i = 0; i < taken; i++) begin
               send_param(8'($urandom));
               sent++;
            end
            open_left = count - taken;
         end else begin
            send_param(8'($urandom));
            if (open_left > 0) begin
               open_left--;
               sent++;
            end
         end
         if (!drained && sent > RANDOM_ITEMS / 2) begin
            drain_packets();
            drained = 1'b1;
         end
      end

      take_stall_max = 10;
      drain_packets();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (tracker.errors == 0 && tracker.bytes_owed() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/sipf_pkg.sv
sv/sipf_channels.sv
sv/sipf_builder.sv
sv/sipf_serializer.sv
sv/servo_instruction_packet_framer_core.sv
sv/sipf_checker.sv
test/tb.sv
